// File: rtl/core/abe_pkg.sv
// Shared types and codes for the allocation bitmap engine.
// No dependencies; imported by abe_ffz, the engine, the checker and the testbench.
`timescale 1ns / 1ps

package abe_pkg;

  localparam int unsigned WORD_W = 64;   // bitmap bits per memory word
  localparam int unsigned BIT_W  = 6;    // bit select within a word
  localparam int unsigned SIZE_W = 13;   // size register width
  localparam int unsigned POS_W  = 12;   // position and range end width

  typedef enum logic [1:0] {
    KIND_FIND   = 2'd0,
    KIND_INVERT = 2'd1,
    KIND_READ   = 2'd2,
    KIND_RANGE  = 2'd3
  } kind_e;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [1:0] STAT_BOUNDS    = 2'd2;

  localparam logic CFG_INODE_BITS = 1'b0;
  localparam logic CFG_DATA_BITS  = 1'b1;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffz_t;

endpackage

// File: rtl/core/abe_bitmap_ram.sv
// One bitmap store: synchronous memory, one write and one read port.
// Read data is registered. Depends on nothing.
`timescale 1ns / 1ps

module abe_bitmap_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned W     = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/abe_ffz.sv
// Find-first-zero over one bitmap word, lowest index first.
// Two levels: eight byte groups, then the first group holding a zero. Uses abe_pkg.
`timescale 1ns / 1ps

module abe_ffz
  import abe_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  output ffz_t              res_o
);

  localparam int unsigned GRP   = 8;
  localparam int unsigned NGRP  = WORD_W / GRP;
  localparam int unsigned GRP_W = 3;

  logic [NGRP-1:0]  grp_any;
  logic [GRP_W-1:0] grp_idx [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = ~&word_i[g*GRP +: GRP];
      grp_idx[g] = '0;
      // scan high to low so the lowest zero wins
      for (int j = GRP - 1; j >= 0; j--) begin
        if (!word_i[g*GRP + j]) begin
          grp_idx[g] = GRP_W'(j);
        end
      end
    end
  end

  always_comb begin
    res_o.found = |grp_any;
    res_o.idx   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        res_o.idx = {GRP_W'(g), grp_idx[g]};
      end
    end
  end

endmodule

// File: rtl/core/allocation_bitmap_engine.sv
// Allocation bitmap engine: inode and data bitmaps in two 64-bit-wide memories.
// A find scans at most ceil(n/64) words (n = inode size in use); a range sweeps the words
// it spans. One request at a time: the next is taken in the cycle after the result loads
// into the output register, so a request is held longer while the output is stalled.
// Reset: a clearing pass zeroes both maps with s_axis_tready low.
`timescale 1ns / 1ps

module allocation_bitmap_engine
  import abe_pkg::*;
#(
  parameter int unsigned MAP_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] position, [23:12] range_end
  input  logic [2:0]  s_axis_tuser,   // [1:0] kind, [2] which_map
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] found_index, [12] bit_value, [15:13] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned WORDS     = MAP_BITS / WORD_W;
  localparam int unsigned AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CAP       = (MAP_BITS > 8191) ? 8191 : MAP_BITS;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FIND  = 6'b000100,
    ST_BIT   = 6'b001000,
    ST_RANGE = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [AW-1:0]       proc_addr_q, proc_addr_d;
  logic [SIZE_W-1:0]   inode_bits_q, data_bits_q;
  logic                out_valid_q, out_valid_d;

  kind_e               kind_q;
  logic                sel_q;
  logic [POS_W-1:0]    pos_q, end_q;
  logic [1:0]          res_status_q, res_status_d;
  logic [POS_W-1:0]    res_found_q, res_found_d;
  logic                res_bit_q, res_bit_d;
  logic [1:0]          out_status_q;
  logic [POS_W-1:0]    out_found_q;
  logic                out_bit_q;

  logic                in_accept, out_load;
  kind_e               in_kind;
  logic                in_which;
  logic [POS_W-1:0]    in_pos, in_end;
  logic [AW-1:0]       in_addr;
  logic [SIZE_W-1:0]   inode_lim, data_lim, sel_lim;
  logic                pos_bad, range_bad;

  logic                inode_we, data_we;
  logic [AW-1:0]       waddr, raddr;
  logic [WORD_W-1:0]   wdata, inode_rd, data_rd, rd_sel, flip_mask, range_mask;
  logic [WORD_W-1:0]   tail_mask, find_word;
  logic [AW-1:0]       pos_w, end_w, last_w;
  logic [BIT_W-1:0]    lo_bit, hi_bit;
  ffz_t                ffz;

  // ---------------------------------------------------------------- decode
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_kind   = kind_e'(s_axis_tuser[1:0]);
  assign in_which  = s_axis_tuser[2];
  assign in_pos    = s_axis_tdata[11:0];
  assign in_end    = s_axis_tdata[23:12];
  assign in_addr   = (in_kind == KIND_FIND) ? '0 : AW'(in_pos >> BIT_W);

  assign inode_lim = (inode_bits_q > SIZE_W'(CAP)) ? SIZE_W'(CAP) : inode_bits_q;
  assign data_lim  = (data_bits_q > SIZE_W'(CAP)) ? SIZE_W'(CAP) : data_bits_q;
  assign sel_lim   = in_which ? inode_lim : data_lim;
  assign pos_bad   = {1'b0, in_pos} >= sel_lim;
  assign range_bad = (in_end < in_pos) || ({1'b0, in_end} >= data_lim);

  assign pos_w  = AW'(pos_q >> BIT_W);
  assign end_w  = AW'(end_q >> BIT_W);
  assign last_w = AW'((inode_lim - SIZE_W'(1)) >> BIT_W);

  // ---------------------------------------------------------------- memories
  assign rd_sel = sel_q ? inode_rd : data_rd;

  // masks for the word under process
  assign lo_bit     = (proc_addr_q == pos_w) ? pos_q[BIT_W-1:0] : '0;
  assign hi_bit     = (proc_addr_q == end_w) ? end_q[BIT_W-1:0] : '1;
  assign range_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
  assign flip_mask  = (state_q == ST_BIT) ? (WORD_W'(1) << pos_q[BIT_W-1:0]) : range_mask;

  // treat bits past the inode size in use as taken
  assign tail_mask = ((proc_addr_q == last_w) && (inode_lim[BIT_W-1:0] != '0)) ?
                     ((WORD_W'(1) << inode_lim[BIT_W-1:0]) - WORD_W'(1)) : '1;
  assign find_word = inode_rd | ~tail_mask;

  assign waddr = (state_q == ST_CLEAR) ? clr_q : proc_addr_q;
  assign wdata = (state_q == ST_CLEAR) ? '0 : (rd_sel ^ flip_mask);
  assign raddr = (state_q == ST_IDLE) ? in_addr : (proc_addr_q + AW'(1));

  abe_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (AW),
    .W     (WORD_W)
  ) u_inode_ram (
    .clk_i   (clk_i),
    .we_i    (inode_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (inode_rd)
  );

  abe_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (AW),
    .W     (WORD_W)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (data_rd)
  );

  abe_ffz u_ffz (
    .word_i (find_word),
    .res_o  (ffz)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    proc_addr_d  = proc_addr_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_bit_d    = res_bit_q;
    inode_we     = 1'b0;
    data_we      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        inode_we = 1'b1;
        data_we  = 1'b1;
        clr_d    = clr_q + AW'(1);
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_status_d = STAT_OK;
          res_found_d  = '0;
          res_bit_d    = 1'b0;
          proc_addr_d  = in_addr;
          unique case (in_kind)
            KIND_FIND: begin
              if (inode_lim == '0) begin
                res_status_d = STAT_NONE_FREE;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_FIND;
              end
            end
            KIND_INVERT, KIND_READ: begin
              if (pos_bad) begin
                res_status_d = STAT_BOUNDS;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_BIT;
              end
            end
            KIND_RANGE: begin
              if (range_bad) begin
                res_status_d = STAT_BOUNDS;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_RANGE;
              end
            end
          endcase
        end
      end
      ST_FIND: begin
        if (ffz.found) begin
          res_found_d = POS_W'({proc_addr_q, ffz.idx});
          state_d     = ST_RESP;
        end else if (proc_addr_q == last_w) begin
          res_status_d = STAT_NONE_FREE;
          state_d      = ST_RESP;
        end else begin
          proc_addr_d = proc_addr_q + AW'(1);
        end
      end
      ST_BIT: begin
        if (kind_q == KIND_INVERT) begin
          inode_we = sel_q;
          data_we  = !sel_q;
        end else begin
          res_bit_d = rd_sel[pos_q[BIT_W-1:0]];
        end
        state_d = ST_RESP;
      end
      ST_RANGE: begin
        data_we = 1'b1;
        if (proc_addr_q == end_w) begin
          state_d = ST_RESP;
        end else begin
          proc_addr_d = proc_addr_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_load    = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      proc_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      inode_bits_q <= SIZE_W'(4096);
      data_bits_q  <= SIZE_W'(4096);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      proc_addr_q <= proc_addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_INODE_BITS) begin
          inode_bits_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_DATA_BITS) begin
          data_bits_q <= cfg_data_i;
        end
      end
    end
  end

  // payload: hold the request and the result fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= in_kind;
      sel_q  <= in_which && (in_kind != KIND_RANGE);
      pos_q  <= in_pos;
      end_q  <= in_end;
    end
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_bit_q    <= res_bit_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_bit_q    <= res_bit_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_bit_q, out_found_q};
  assign m_axis_tuser  = out_status_q;
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- checks
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> !(inode_we || data_we))
    else $error("bitmap write outside a working state");

  a_range_in_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANGE) |-> (proc_addr_q <= end_w))
    else $error("range sweep ran past its last word");

  a_bounds_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STAT_BOUNDS)) |-> (m_axis_tdata == '0))
    else $error("bounds error result carries data");

endmodule

// File: sim/abe_checker.sv
// Scoreboard for the allocation bitmap engine: watches the request, reply and
// configuration channels, keeps its own copy of both bitmaps and compares replies.
// Depends on abe_pkg for field widths, request kinds and status codes.
`timescale 1ns / 1ps

module abe_checker
  import abe_pkg::*;
#(
  parameter int unsigned MAP_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [23:0] req_data_i,   // [11:0] position, [23:12] range_end
  input  logic [2:0]  req_user_i,   // [1:0] kind, [2] which_map
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [15:0] rsp_data_i,   // [11:0] found_index, [12] bit_value, [15:13] zero
  input  logic [1:0]  rsp_user_i,   // [1:0] status
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] found_index;
    logic             bit_value;
  } reply_t;

  bit               inode_used [MAP_BITS];
  bit               block_used [MAP_BITS];
  logic [SIZE_W-1:0] inode_size_reg;
  logic [SIZE_W-1:0] data_size_reg;
  reply_t           pending_replies [$];
  int unsigned      error_count;

  function automatic int unsigned bits_in_use(logic [SIZE_W-1:0] size_val);
    return (size_val > MAP_BITS) ? MAP_BITS : int'(size_val);
  endfunction

  // Apply one request to the bitmap copies and return the reply it must produce.
  function automatic reply_t apply_request(kind_e kind, logic which, logic [POS_W-1:0] pos,
                                           logic [POS_W-1:0] last);
    reply_t      rep;
    int unsigned lim;
    int unsigned i;
    rep = '0;
    rep.status = STAT_OK;
    lim = bits_in_use(which ? inode_size_reg : data_size_reg);
    case (kind)
      KIND_FIND: begin
        rep.status = STAT_NONE_FREE;
        for (i = 0; i < bits_in_use(inode_size_reg); i++) begin
          if (!inode_used[i]) begin
            rep.status = STAT_OK;
            rep.found_index = POS_W'(i);
            break;
          end
        end
      end
      KIND_INVERT: begin
        if (pos >= lim) rep.status = STAT_BOUNDS;
        else if (which) inode_used[pos] = !inode_used[pos];
        else block_used[pos] = !block_used[pos];
      end
      KIND_READ: begin
        if (pos >= lim) rep.status = STAT_BOUNDS;
        else rep.bit_value = which ? inode_used[pos] : block_used[pos];
      end
      default: begin
        // range always targets the data map
        if (last < pos || last >= bits_in_use(data_size_reg)) begin
          rep.status = STAT_BOUNDS;
        end else begin
          for (i = pos; i <= last; i++) block_used[i] = !block_used[i];
        end
      end
    endcase
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      foreach (inode_used[i]) inode_used[i] = 1'b0;
      foreach (block_used[i]) block_used[i] = 1'b0;
      inode_size_reg = SIZE_W'(MAP_BITS);
      data_size_reg  = SIZE_W'(MAP_BITS);
      pending_replies.delete();
      error_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_INODE_BITS) inode_size_reg = cfg_data_i;
        else data_size_reg = cfg_data_i;
      end
      if (req_valid_i && req_ready_i) begin
        pending_replies.push_back(apply_request(kind_e'(req_user_i[1:0]), req_user_i[2],
                                                req_data_i[11:0], req_data_i[23:12]));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_replies.size() == 0) begin
          $error("reply transfer with no request outstanding");
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          got.status      = rsp_user_i;
          got.found_index = rsp_data_i[11:0];
          got.bit_value   = rsp_data_i[12];
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, got.found_index);
            error_count++;
          end
          if (got.bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, actual %0d", want.bit_value, got.bit_value);
            error_count++;
          end
        end
      end
      pending_o <= pending_replies.size();
      errors_o  <= error_count;
    end
  end

endmodule

// File: sim/testbench.sv
// Top of the allocation bitmap engine testbench: clock, reset, request and
// configuration stimulus, reply backpressure, watchdog and verdict.
// Depends on abe_pkg, allocation_bitmap_engine and abe_checker.
`timescale 1ns / 1ps

module testbench;
  import abe_pkg::*;

  localparam int unsigned MAP_BITS    = 4096;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 140;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = CFG_INODE_BITS;
  logic [12:0] cfg_data_i    = '0;

  int unsigned replies_pending;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  int unsigned sink_hold = 0;
  bit          sink_stalls = 1'b1;
  bit          source_bursting = 1'b0;
  int unsigned inode_lim = MAP_BITS;
  int unsigned data_lim = MAP_BITS;
  int unsigned alloc_cursor = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  allocation_bitmap_engine #(.MAP_BITS(MAP_BITS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  abe_checker #(.MAP_BITS(MAP_BITS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .rsp_valid_i (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),
    .rsp_user_i  (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (replies_pending),
    .errors_o    (mismatches)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 94) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // end the run if no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reply backpressure; stalling switches on and off now and then
  always @(posedge clk_i) begin
    if ($urandom_range(0, 399) == 0) sink_stalls = !sink_stalls;
    if (sink_hold != 0) begin
      sink_hold = sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 3) == 0) sink_hold = gap_length();
    end
  end

  // valid is lowered here only ahead of a gap (and by wait_idle), so a back-to-back request keeps it high
  task automatic send_request(kind_e kind, logic which, logic [11:0] pos, logic [11:0] last);
    int unsigned gap;
    gap = (source_bursting || $urandom_range(0, 1) == 0) ? 0 : gap_length();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {last, pos};
    s_axis_tuser  <= {which, kind};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (replies_pending != 0);
  endtask

  task automatic write_size(logic idx, logic [12:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_INODE_BITS) inode_lim = (value > MAP_BITS) ? MAP_BITS : value;
    else data_lim = (value > MAP_BITS) ? MAP_BITS : value;
  endtask

  task automatic set_sizes(logic [12:0] inode_bits, logic [12:0] data_bits);
    write_size(CFG_INODE_BITS, inode_bits);
    write_size(CFG_DATA_BITS, data_bits);
    alloc_cursor = 0;
  endtask

  // mostly inside the map in use, with its edges and stray positions mixed in
  function automatic logic [11:0] pick_position(int unsigned lim);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (lim == 0 || roll == 0) return 12'($urandom_range(0, 4095));
    if (roll == 1) return 12'(lim - 1);
    if (roll == 2 && lim < MAP_BITS) return 12'(lim);
    return 12'($urandom_range(0, lim - 1));
  endfunction

  task automatic random_request();
    int unsigned roll;
    int unsigned start;
    int unsigned span;
    logic        which;
    logic [11:0] pos;
    logic [11:0] last;
    roll  = $urandom_range(0, 99);
    which = 1'($urandom_range(0, 1));
    if (roll < 20) begin
      send_request(KIND_FIND, which, 12'($urandom), 12'($urandom));
    end else if (roll < 75) begin
      // half of the inode inversions and reads walk a cursor so the map fills up in order
      if (which && inode_lim != 0 && $urandom_range(0, 1) == 1) begin
        pos = 12'(alloc_cursor);
        alloc_cursor = (alloc_cursor + 1) % inode_lim;
      end else begin
        pos = pick_position(which ? inode_lim : data_lim);
      end
      send_request((roll < 50) ? KIND_INVERT : KIND_READ, which, pos, 12'($urandom));
    end else begin
      if (data_lim != 0 && $urandom_range(0, 6) != 0) begin
        start = $urandom_range(0, data_lim - 1);
        span  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, data_lim - 1)
                                            : $urandom_range(0, 70);
        pos   = 12'(start);
        last  = 12'((start + span >= data_lim) ? data_lim - 1 : start + span);
      end else begin
        pos  = 12'($urandom);
        last = 12'($urandom);
      end
      send_request(KIND_RANGE, which, pos, last);
    end
  endtask

  initial begin
    logic [12:0] inode_table [8];
    logic [12:0] data_table [8];
    inode_table = '{13'd4096, 13'd8, 13'd8191, 13'd64, 13'd100, 13'd4096, 13'd4097, 13'd9};
    data_table  = '{13'd4096, 13'd8, 13'd8191, 13'd65, 13'd4096, 13'd8, 13'd63, 13'd1000};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset sizes
    send_request(KIND_FIND, 1'b0, 12'd0, 12'd0);
    send_request(KIND_READ, 1'b0, 12'd0, 12'd0);
    send_request(KIND_INVERT, 1'b1, 12'd0, 12'd0);
    send_request(KIND_FIND, 1'b1, 12'hfff, 12'hfff);
    send_request(KIND_READ, 1'b1, 12'd0, 12'd0);
    send_request(KIND_INVERT, 1'b1, 12'hfff, 12'd0);
    send_request(KIND_READ, 1'b1, 12'hfff, 12'hfff);
    send_request(KIND_INVERT, 1'b0, 12'hfff, 12'd0);
    send_request(KIND_RANGE, 1'b0, 12'd0, 12'hfff);
    send_request(KIND_READ, 1'b0, 12'hfff, 12'd0);
    send_request(KIND_READ, 1'b0, 12'h800, 12'd0);
    send_request(KIND_RANGE, 1'b1, 12'd63, 12'd64);
    send_request(KIND_RANGE, 1'b0, 12'd5, 12'd4);
    send_request(KIND_RANGE, 1'b0, 12'd100, 12'd100);

    // one inode bit, already taken: find reports none free
    wait_idle();
    set_sizes(13'd1, 13'd8);
    send_request(KIND_FIND, 1'b0, 12'd0, 12'd0);
    send_request(KIND_INVERT, 1'b1, 12'd1, 12'd0);
    send_request(KIND_READ, 1'b0, 12'd8, 12'd0);
    send_request(KIND_RANGE, 1'b0, 12'd0, 12'd8);
    send_request(KIND_RANGE, 1'b0, 12'd0, 12'd7);

    // zero sizes: nothing is in bounds
    wait_idle();
    set_sizes(13'd0, 13'd0);
    send_request(KIND_FIND, 1'b1, 12'd0, 12'd0);
    send_request(KIND_READ, 1'b0, 12'd0, 12'd0);
    send_request(KIND_INVERT, 1'b1, 12'd0, 12'd0);
    send_request(KIND_RANGE, 1'b0, 12'd0, 12'd0);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      if (phase < 8) set_sizes(inode_table[phase], data_table[phase]);
      else set_sizes(13'($urandom_range(8, 4096)), 13'($urandom_range(8, 4096)));
      source_bursting = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_request();
    end

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
